// ===== hdl/falru_pkg.sv =====
package falru_pkg;

  localparam int NUM_BLOCKS         = 64;
  localparam int BLOCK_BYTES        = 64;
  localparam int MIN_TRACKED_BLOCKS = 8;
  localparam int ADDR_BITS          = 32;

  localparam int ADDR_W      = 32;
  localparam int MASK_BITS   = 3;
  localparam int ENTRY_W     = 6;
  localparam int IDX_W       = $clog2(NUM_BLOCKS);
  localparam int CNT_W       = $clog2(NUM_BLOCKS + 1);
  localparam int OFFSET_BITS = $clog2(BLOCK_BYTES);
  localparam int TAG_W       = ADDR_BITS - OFFSET_BITS;

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_PROBE  = 2'd1,
    OP_FILL   = 2'd2,
    OP_INVAL  = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [ADDR_W-1:0]   address;
  } in_beat_t;

  typedef struct packed {
    logic                 hit;
    logic [MASK_BITS-1:0] in_cache_mask;
    logic [ENTRY_W-1:0]   entry_index;
    logic                 victim_was_valid;
    logic                 warmed_up;
  } out_beat_t;

  typedef struct packed {
    logic             fill;
    logic [IDX_W-1:0] fill_idx;
    logic             clear;
    logic [IDX_W-1:0] clear_idx;
  } cam_upd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] rank;
  } rank_upd_t;

endpackage

// ===== hdl/falru_cam.sv =====
module falru_cam (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [falru_pkg::TAG_W-1:0] tag_i,
  input  falru_pkg::cam_upd_t         upd_i,
  output logic [falru_pkg::NUM_BLOCKS-1:0] match_o,
  output logic [falru_pkg::NUM_BLOCKS-1:0] valid_o
);

  logic [falru_pkg::TAG_W-1:0]      tags_q [falru_pkg::NUM_BLOCKS];
  logic [falru_pkg::NUM_BLOCKS-1:0] valid_q;

  always_ff @(posedge clk_i) begin
    if (upd_i.fill) begin
      tags_q[upd_i.fill_idx] <= tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (upd_i.fill) begin
        valid_q[upd_i.fill_idx] <= 1'b1;
      end
      if (upd_i.clear) begin
        valid_q[upd_i.clear_idx] <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < falru_pkg::NUM_BLOCKS; k++) begin
      match_o[k] = valid_q[k] && (tags_q[k] == tag_i);
    end
  end

  assign valid_o = valid_q;

endmodule

// ===== hdl/falru_rank.sv =====
module falru_rank (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [falru_pkg::IDX_W-1:0] rd_idx_i,
  input  falru_pkg::rank_upd_t        upd_i,
  output logic [falru_pkg::IDX_W-1:0] rd_rank_o,
  output logic [falru_pkg::IDX_W-1:0] victim_o
);

  localparam logic [falru_pkg::IDX_W-1:0] TailRank =
    falru_pkg::IDX_W'(falru_pkg::NUM_BLOCKS - 1);

  logic [falru_pkg::IDX_W-1:0] rank_q [falru_pkg::NUM_BLOCKS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < falru_pkg::NUM_BLOCKS; k++) begin
        rank_q[k] <= falru_pkg::IDX_W'(k);
      end
    end else if (upd_i.en) begin
      for (int k = 0; k < falru_pkg::NUM_BLOCKS; k++) begin
        if (falru_pkg::IDX_W'(k) == upd_i.idx) begin
          rank_q[k] <= '0;
        end else if (rank_q[k] < upd_i.rank) begin
          rank_q[k] <= rank_q[k] + 1'b1;
        end
      end
    end
  end

  assign rd_rank_o = rank_q[rd_idx_i];

  always_comb begin
    victim_o = '0;
    for (int k = 0; k < falru_pkg::NUM_BLOCKS; k++) begin
      if (rank_q[k] == TailRank) begin
        victim_o = falru_pkg::IDX_W'(k);
      end
    end
  end

endmodule

// ===== hdl/fa_lru_tag_store_multisize.sv =====
// Channel | Dir | Handshake              | Beat
// in      | in  | in_valid_i/in_stall_o  | in_beat_i   (opcode, address)
// out     | out | out_valid_o/out_stall_i| out_beat_o  (hit, mask, index, victim, warm)
//
// One beat per cycle sustained while the output is not stalled: input register,
// one pass of tag compare, LRU rank update and counters, then the result register.
// An accepted beat is held in the input register, and its result is then registered in the result register.
// Reset clears valid bits, ranks (entry i at rank i), fill count and warm flag.
// A stall on the output holds the result register and, while it holds a beat, the input register.
module fa_lru_tag_store_multisize (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  falru_pkg::in_beat_t  in_beat_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output falru_pkg::out_beat_t out_beat_o
);

  logic                              in_valid_q;
  falru_pkg::in_beat_t               in_q;
  logic                              out_valid_q;
  falru_pkg::out_beat_t              out_q, out_d;
  logic [falru_pkg::CNT_W-1:0]       used_q, used_d;
  logic                              warm_q, warm_d;

  logic                              advance, work;
  logic [falru_pkg::TAG_W-1:0]       tag;
  logic [falru_pkg::NUM_BLOCKS-1:0]  match, valid;
  logic                              hit;
  logic [falru_pkg::IDX_W-1:0]       found, victim, hit_rank, index;
  logic                              vwas;
  logic [falru_pkg::MASK_BITS-1:0]   mask;
  falru_pkg::cam_upd_t               cam_upd;
  falru_pkg::rank_upd_t              rank_upd;

  assign advance    = !out_valid_q || !out_stall_i;
  assign work       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign tag        = in_q.address[falru_pkg::ADDR_BITS-1:falru_pkg::OFFSET_BITS];

  falru_cam u_cam (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tag),
    .upd_i   (cam_upd),
    .match_o (match),
    .valid_o (valid)
  );

  falru_rank u_rank (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_idx_i  (found),
    .upd_i     (rank_upd),
    .rd_rank_o (hit_rank),
    .victim_o  (victim)
  );

  always_comb begin
    found = '0;
    for (int k = falru_pkg::NUM_BLOCKS - 1; k >= 0; k--) begin
      if (match[k]) begin
        found = falru_pkg::IDX_W'(k);
      end
    end
  end

  assign hit = |match;

  always_comb begin
    for (int i = 0; i < falru_pkg::MASK_BITS; i++) begin
      mask[i] = hit
             && ((falru_pkg::MIN_TRACKED_BLOCKS << i) < falru_pkg::NUM_BLOCKS)
             && (int'(hit_rank) < (falru_pkg::MIN_TRACKED_BLOCKS << i));
    end
  end

  always_comb begin
    cam_upd  = '0;
    rank_upd = '0;
    vwas     = 1'b0;
    index    = hit ? found : '0;
    used_d   = used_q;
    warm_d   = warm_q;
    case (in_q.opcode)
      falru_pkg::OP_ACCESS: begin
        rank_upd.en   = work && hit;
        rank_upd.idx  = found;
        rank_upd.rank = hit_rank;
      end
      falru_pkg::OP_FILL: begin
        vwas             = valid[victim];
        index            = victim;
        rank_upd.en      = work;
        rank_upd.idx     = victim;
        rank_upd.rank    = falru_pkg::IDX_W'(falru_pkg::NUM_BLOCKS - 1);
        cam_upd.fill     = work;
        cam_upd.fill_idx = victim;
        if (!vwas) begin
          if (used_q < falru_pkg::CNT_W'(falru_pkg::NUM_BLOCKS)) begin
            used_d = used_q + 1'b1;
          end
          if (used_d >= falru_pkg::CNT_W'(falru_pkg::NUM_BLOCKS)) begin
            warm_d = 1'b1;
          end
        end
      end
      falru_pkg::OP_INVAL: begin
        cam_upd.clear     = work && hit;
        cam_upd.clear_idx = found;
        if (hit && used_q != '0) begin
          used_d = used_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_d.hit              = hit;
    out_d.in_cache_mask    = mask;
    out_d.entry_index      = falru_pkg::ENTRY_W'(index);
    out_d.victim_was_valid = vwas;
    out_d.warmed_up        = warm_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      warm_q      <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
      if (work) begin
        used_q <= used_d;
        warm_q <= warm_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_beat_i;
    end
    if (work) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;

  typedef struct {
    falru_pkg::in_beat_t beat;
    bit                  drain_first;
  } req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  falru_pkg::in_beat_t  in_beat_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  falru_pkg::out_beat_t out_beat_o;

  fa_lru_tag_store_multisize i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the tag store
  logic [falru_pkg::TAG_W-1:0] line_tag[falru_pkg::NUM_BLOCKS];
  bit                          line_valid[falru_pkg::NUM_BLOCKS];
  int unsigned                 line_rank[falru_pkg::NUM_BLOCKS];
  int unsigned                 lines_in_use;
  bit                          warm_seen;

  req_t                        req_q[$];
  falru_pkg::out_beat_t        pending_results[$];
  logic [falru_pkg::TAG_W-1:0] tag_pool[128];
  int unsigned                 pool_spans[6] = '{6, 12, 24, 40, 72, 128};

  int unsigned beats_in = 0;
  int unsigned beats_total = 0;
  int unsigned mismatches = 0;
  bit          in_taken = 1'b0;
  int unsigned snd_gap = 0;
  int unsigned snd_calm = 0;
  int unsigned rcv_hold = 0;
  int unsigned rcv_calm = 0;
  bit          long_hold_done = 1'b0;

  function automatic void promote(int e);
    int unsigned r;
    r = line_rank[e];
    for (int k = 0; k < falru_pkg::NUM_BLOCKS; k++)
      if (line_rank[k] < r) line_rank[k]++;
    line_rank[e] = 0;
  endfunction

  function automatic falru_pkg::out_beat_t lookup_and_update(falru_pkg::in_beat_t b);
    logic [falru_pkg::TAG_W-1:0] t;
    int                          found;
    int                          victim;
    falru_pkg::out_beat_t        res;
    t = falru_pkg::TAG_W'(b.address >> falru_pkg::OFFSET_BITS);
    found = -1;
    victim = 0;
    res = '0;
    for (int k = 0; k < falru_pkg::NUM_BLOCKS; k++)
      if (found < 0 && line_valid[k] && line_tag[k] == t) found = k;
    if (found >= 0) begin
      res.hit = 1'b1;
      res.entry_index = falru_pkg::ENTRY_W'(found);
      for (int i = 0; i < falru_pkg::MASK_BITS; i++)
        if ((falru_pkg::MIN_TRACKED_BLOCKS << i) < falru_pkg::NUM_BLOCKS &&
            line_rank[found] < (falru_pkg::MIN_TRACKED_BLOCKS << i))
          res.in_cache_mask[i] = 1'b1;
    end
    case (b.opcode)
      falru_pkg::OP_ACCESS: begin
        if (found >= 0) promote(found);
      end
      falru_pkg::OP_PROBE: ;
      falru_pkg::OP_FILL: begin
        for (int k = 0; k < falru_pkg::NUM_BLOCKS; k++)
          if (line_rank[k] == falru_pkg::NUM_BLOCKS - 1) victim = k;
        res.victim_was_valid = line_valid[victim];
        promote(victim);
        line_tag[victim] = t;
        if (!res.victim_was_valid) begin
          if (lines_in_use < falru_pkg::NUM_BLOCKS) lines_in_use++;
          if (lines_in_use >= falru_pkg::NUM_BLOCKS) warm_seen = 1'b1;
        end
        line_valid[victim] = 1'b1;
        res.entry_index = falru_pkg::ENTRY_W'(victim);
      end
      falru_pkg::OP_INVAL: begin
        if (found >= 0) begin
          line_valid[found] = 1'b0;
          if (lines_in_use > 0) lines_in_use--;
        end
      end
      default: ;
    endcase
    res.warmed_up = warm_seen;
    return res;
  endfunction

  function automatic int unsigned next_gap(ref int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(20, 100);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want)
      note_failure($sformatf("%s: expected %0h, got %0h", name, want, got));
  endtask

  task automatic check_result(falru_pkg::out_beat_t got);
    falru_pkg::out_beat_t want;
    if (pending_results.size() == 0) begin
      note_failure($sformatf("result beat with nothing expected: %p", got));
      return;
    end
    want = pending_results.pop_front();
    check_field("hit", want.hit, got.hit);
    check_field("in_cache_mask", want.in_cache_mask, got.in_cache_mask);
    check_field("entry_index", want.entry_index, got.entry_index);
    check_field("victim_was_valid", want.victim_was_valid, got.victim_was_valid);
    check_field("warmed_up", want.warmed_up, got.warmed_up);
  endtask

  task automatic queue_op(falru_pkg::opcode_e op, logic [falru_pkg::ADDR_W-1:0] a,
                          bit drain);
    req_t q;
    q.beat.opcode = op;
    q.beat.address = a;
    q.drain_first = drain;
    req_q.push_back(q);
  endtask

  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pending_results.push_back(lookup_and_update(in_beat_i));
        beats_in++;
      end
      if (out_valid_o && !out_stall_i) check_result(out_beat_o);
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold the stalled beat
    end else if (snd_gap > 0) begin
      in_valid_i <= 1'b0;
      snd_gap--;
    end else if (req_q.size() != 0 &&
                 !(req_q[0].drain_first && pending_results.size() != 0)) begin
      in_valid_i <= 1'b1;
      in_beat_i <= req_q[0].beat;
      req_q.pop_front();
      snd_gap = next_gap(snd_calm);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rcv_hold > 0) begin
      out_stall_i <= 1'b1;
      rcv_hold--;
    end else if (!long_hold_done && beats_in >= 400) begin
      long_hold_done = 1'b1;
      rcv_hold = 299;
      out_stall_i <= 1'b1;
    end else begin
      rcv_hold = next_gap(rcv_calm);
      if (rcv_hold > 0) begin
        out_stall_i <= 1'b1;
        rcv_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    int unsigned                   r;
    int unsigned                   span;
    falru_pkg::opcode_e            op;
    logic [falru_pkg::ADDR_W-1:0]  a;
    for (int k = 0; k < falru_pkg::NUM_BLOCKS; k++) begin
      line_rank[k] = k;
      line_valid[k] = 1'b0;
    end
    lines_in_use = 0;
    warm_seen = 1'b0;
    for (int k = 0; k < 128; k++) tag_pool[k] = falru_pkg::TAG_W'($urandom());

    queue_op(falru_pkg::OP_ACCESS, 32'h0000_0000, 1'b0);
    queue_op(falru_pkg::OP_PROBE,  32'hFFFF_FFFF, 1'b0);
    queue_op(falru_pkg::OP_INVAL,  32'h1234_5678, 1'b0);
    queue_op(falru_pkg::OP_FILL,   32'h0000_0000, 1'b0);
    queue_op(falru_pkg::OP_FILL,   32'hFFFF_FFFF, 1'b0);
    queue_op(falru_pkg::OP_ACCESS, 32'h0000_003F, 1'b0);
    queue_op(falru_pkg::OP_PROBE,  32'hFFFF_FFC0, 1'b0);
    queue_op(falru_pkg::OP_FILL,   32'hFFFF_FFFF, 1'b0);
    queue_op(falru_pkg::OP_ACCESS, 32'hFFFF_FFE5, 1'b0);
    queue_op(falru_pkg::OP_INVAL,  32'hFFFF_FFFF, 1'b0);
    queue_op(falru_pkg::OP_PROBE,  32'hFFFF_FFFF, 1'b0);
    queue_op(falru_pkg::OP_INVAL,  32'hFFFF_FFFF, 1'b0);
    queue_op(falru_pkg::OP_PROBE,  32'hFFFF_FFFF, 1'b0);
    queue_op(falru_pkg::OP_INVAL,  32'h0000_0000, 1'b0);
    queue_op(falru_pkg::OP_FILL,   32'hAAAA_AAAA, 1'b0);
    queue_op(falru_pkg::OP_FILL,   32'h5555_5555, 1'b0);
    queue_op(falru_pkg::OP_ACCESS, 32'h5555_5555, 1'b0);
    queue_op(falru_pkg::OP_ACCESS, 32'hAAAA_AAAA, 1'b0);
    queue_op(falru_pkg::OP_INVAL,  32'h0000_0040, 1'b0);

    for (int c = 0; c < 36; c++) begin
      span = pool_spans[$urandom_range(0, 5)];
      for (int j = 0; j < 40; j++) begin
        r = $urandom_range(0, 99);
        op = r < 40 ? falru_pkg::OP_ACCESS :
             r < 55 ? falru_pkg::OP_PROBE  :
             r < 85 ? falru_pkg::OP_FILL   : falru_pkg::OP_INVAL;
        if ($urandom_range(0, 19) == 0)
          a = $urandom();
        else
          a = {tag_pool[$urandom_range(0, span - 1)],
               falru_pkg::OFFSET_BITS'($urandom())};
        queue_op(op, a, (c == 0 || c == 18) && j == 0);
      end
    end
    beats_total = req_q.size();

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (beats_in != beats_total) @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("[fa_lru_tag_store_multisize] OK");
    else
      $display("[fa_lru_tag_store_multisize] ERROR");
    $finish;
  end

  initial begin
    #8000000;
    $display("[fa_lru_tag_store_multisize] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/falru_pkg.sv
hdl/falru_cam.sv
hdl/falru_rank.sv
hdl/fa_lru_tag_store_multisize.sv
tb/sv/tb.sv
